// ===== design/touch_coordinate_calibrator_defines.svh =====
// Assertion macros shared by the touch coordinate calibrator RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef TOUCH_COORDINATE_CALIBRATOR_DEFINES_SVH
`define TOUCH_COORDINATE_CALIBRATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, off while reset is asserted
`define TCC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
// Clocked check that also holds during reset
`define TCC_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");
`else
`define TCC_ASSERT(name, prop)
`define TCC_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== design/tcc_pkg.sv =====
// Shared widths, defaults and register codes of the touch coordinate calibrator.
// Used by the channel interfaces and the top level.
package tcc_pkg;

  localparam int RAW_W   = 13;
  localparam int OFS_W   = 9;
  localparam int COORD_W = 9;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 3;

  localparam int DEF_SCREEN_WIDTH  = 480;
  localparam int DEF_SCREEN_HEIGHT = 320;

  localparam logic [RAW_W-1:0] RAW_MIN_RESET = 13'd0;
  localparam logic [RAW_W-1:0] RAW_MAX_RESET = 13'd4095;
  localparam logic [OFS_W-1:0] OFS_RESET     = 9'd0;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_HORIZ_MIN = 3'd0,
    REG_HORIZ_MAX = 3'd1,
    REG_VERT_MIN  = 3'd2,
    REG_VERT_MAX  = 3'd3,
    REG_HORIZ_OFS = 3'd4,
    REG_VERT_OFS  = 3'd5
  } cfg_reg_e;

  // Axis codes of the command field
  localparam logic AXIS_HORIZ = 1'b0;
  localparam logic AXIS_VERT  = 1'b1;

endpackage

// ===== design/tcc_in_if.sv =====
// Input channel of the calibrator: axis command and the two converter bytes.
// Depends on tcc_pkg for field widths.
interface tcc_in_if import tcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [BYTE_W-1:0] high_byte;
  logic [BYTE_W-1:0] low_byte;

  modport source (output valid, command, high_byte, low_byte, input ready);
  modport sink   (input valid, command, high_byte, low_byte, output ready);
endinterface

// ===== design/tcc_out_if.sv =====
// Output channel of the calibrator: raw reading, pixel coordinate, axis echo.
// Depends on tcc_pkg for field widths.
interface tcc_out_if import tcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RAW_W-1:0]   raw_reading;
  logic [COORD_W-1:0] screen_coord;
  logic               axis_done;

  modport source (output valid, raw_reading, screen_coord, axis_done, input ready);
  modport sink   (input valid, raw_reading, screen_coord, axis_done, output ready);
endinterface

// ===== design/touch_coordinate_calibrator.sv =====
// Touch coordinate calibrator. Each item carries an axis command and the two
// bytes read back from a resistive touch converter; the block forms the 13-bit
// raw reading, clamps it to the axis window, scales it to the screen span,
// mirrors it, adds the signed axis offset and clamps to the screen. One item
// enters per cycle when the output side keeps up. The stages are one window
// stage, one multiply stage, one restoring divider stage per quotient bit,
// where SW = clog2(max(SCREEN_WIDTH, SCREEN_HEIGHT)+1) is the width of the
// quotient, and one offset/clamp stage. Every stage holds its
// item while the stage after it is full and stalled, so bubbles close up and
// the input stays ready while a finished result waits, until every stage
// holds an item. Configuration writes take effect on the next item and must
// be made while the pipeline is empty.
// Depends on tcc_pkg, tcc_in_if, tcc_out_if and tcc_div_step.
`include "touch_coordinate_calibrator_defines.svh"

module touch_coordinate_calibrator import tcc_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [RAW_W-1:0] cfg_data_i,
  tcc_in_if.sink           in_i,
  tcc_out_if.source        out_o
);

  localparam int SPAN_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int SW       = $clog2(SPAN_MAX + 1);
  localparam int PW       = RAW_W + SW;
  localparam int CW       = (SW + 2 > OFS_W + 1) ? SW + 2 : OFS_W + 1;
  localparam int N        = SW + 3;
  localparam int DIV_LAST = N - 2;

  localparam logic [SW-1:0] SPAN_H = SW'(SCREEN_WIDTH);
  localparam logic [SW-1:0] SPAN_V = SW'(SCREEN_HEIGHT);

  typedef struct packed {
    logic               cmd;
    logic [RAW_W-1:0]   raw;
    logic [SW-1:0]      span;
    logic [OFS_W-1:0]   ofs;
    logic [RAW_W-1:0]   den;
    logic [PW-1:0]      rem;
    logic [SW-1:0]      quo;
    logic [COORD_W-1:0] coord;
  } stage_t;

  // Configuration registers
  logic [RAW_W-1:0] horiz_min_q, horiz_max_q, vert_min_q, vert_max_q;
  logic [OFS_W-1:0] horiz_ofs_q, vert_ofs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horiz_min_q <= RAW_MIN_RESET;
      horiz_max_q <= RAW_MAX_RESET;
      vert_min_q  <= RAW_MIN_RESET;
      vert_max_q  <= RAW_MAX_RESET;
      horiz_ofs_q <= OFS_RESET;
      vert_ofs_q  <= OFS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_HORIZ_MIN: horiz_min_q <= cfg_data_i;
        REG_HORIZ_MAX: horiz_max_q <= cfg_data_i;
        REG_VERT_MIN:  vert_min_q  <= cfg_data_i;
        REG_VERT_MAX:  vert_max_q  <= cfg_data_i;
        REG_HORIZ_OFS: horiz_ofs_q <= cfg_data_i[OFS_W-1:0];
        REG_VERT_OFS:  vert_ofs_q  <= cfg_data_i[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline valid bits and stall chain
  logic [N-1:0] valid_q;
  logic [N:0]   adv;
  logic [N-1:0] vin;
  stage_t       stage_d [N];
  stage_t       stage_q [N];

  always_comb begin
    adv[N] = out_o.ready;
    for (int k = N - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign vin = {valid_q[N-2:0], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (adv[k]) begin
          valid_q[k] <= vin[k];
        end
      end
    end
  end

  // Stage logic and payload registers
  for (genvar k = 0; k < N; k++) begin : g_stage
    if (k == 0) begin : g_window
      logic [RAW_W-1:0] raw, win_lo, win_hi, clamped;
      always_comb begin
        raw     = {in_i.high_byte, in_i.low_byte[BYTE_W-1:3]};
        win_lo  = (in_i.command == AXIS_VERT) ? vert_min_q : horiz_min_q;
        win_hi  = (in_i.command == AXIS_VERT) ? vert_max_q : horiz_max_q;
        clamped = raw;
        if (raw < win_lo) begin
          clamped = win_lo;
        end else if (raw > win_hi) begin
          clamped = win_hi;
        end
        stage_d[k].cmd   = in_i.command;
        stage_d[k].raw   = raw;
        stage_d[k].span  = (in_i.command == AXIS_VERT) ? SPAN_V : SPAN_H;
        stage_d[k].ofs   = (in_i.command == AXIS_VERT) ? vert_ofs_q : horiz_ofs_q;
        stage_d[k].quo   = '0;
        stage_d[k].coord = '0;
        // Empty window: zero over one gives a scaled value of zero
        if (win_hi <= win_lo) begin
          stage_d[k].rem = '0;
          stage_d[k].den = RAW_W'(1);
        end else begin
          stage_d[k].rem = PW'(clamped - win_lo);
          stage_d[k].den = win_hi - win_lo;
        end
      end
    end else if (k == 1) begin : g_mult
      always_comb begin
        stage_d[k]     = stage_q[k-1];
        stage_d[k].rem = {{SW{1'b0}}, stage_q[k-1].rem[RAW_W-1:0]}
                       * {{RAW_W{1'b0}}, stage_q[k-1].span};
      end
    end else if (k <= DIV_LAST) begin : g_div
      logic [PW-1:0] rem_nx;
      logic [SW-1:0] quo_nx;
      tcc_div_step #(
        .PW    (PW),
        .DW    (RAW_W),
        .QW    (SW),
        .SHIFT (DIV_LAST - k)
      ) u_step (
        .rem_i (stage_q[k-1].rem),
        .den_i (stage_q[k-1].den),
        .q_i   (stage_q[k-1].quo),
        .rem_o (rem_nx),
        .q_o   (quo_nx)
      );
      always_comb begin
        stage_d[k]     = stage_q[k-1];
        stage_d[k].rem = rem_nx;
        stage_d[k].quo = quo_nx;
      end
    end else begin : g_final
      logic signed [CW-1:0] sum, span_s;
      logic        [CW-1:0] res;
      always_comb begin
        span_s = signed'(CW'(stage_q[k-1].span));
        // Mirror, shift by the offset, clamp to the screen
        sum = span_s - signed'(CW'(stage_q[k-1].quo))
            + signed'({{(CW-OFS_W){stage_q[k-1].ofs[OFS_W-1]}}, stage_q[k-1].ofs});
        if (sum < 0) begin
          res = '0;
        end else if (sum >= span_s) begin
          res = unsigned'(span_s) - CW'(1);
        end else begin
          res = unsigned'(sum);
        end
        stage_d[k]       = stage_q[k-1];
        stage_d[k].coord = res[COORD_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k] && vin[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  // Ports
  assign in_i.ready         = adv[0];
  assign out_o.valid        = valid_q[N-1];
  assign out_o.raw_reading  = stage_q[N-1].raw;
  assign out_o.screen_coord = stage_q[N-1].coord;
  assign out_o.axis_done    = stage_q[N-1].cmd;

  // An accepted item lands in the window stage
  `TCC_ASSERT(a_accept_lands, (in_i.valid && in_i.ready) |=> valid_q[0])
  // A full window stage that cannot move keeps its item
  `TCC_ASSERT(a_front_holds, (valid_q[0] && !adv[1]) |=> valid_q[0])
  // The divider leaves a remainder below the divisor
  `TCC_ASSERT(a_rem_below_den,
    valid_q[DIV_LAST] |-> (stage_q[DIV_LAST].rem < PW'(stage_q[DIV_LAST].den)))
  // Coordinates stay on the screen when the field can hold the span
  `TCC_ASSERT(a_coord_on_screen,
    out_o.valid |-> ((SW > COORD_W) ||
      (out_o.axis_done ? (int'(out_o.screen_coord) < SCREEN_HEIGHT)
                       : (int'(out_o.screen_coord) < SCREEN_WIDTH))))
  // No item is valid anywhere right after reset
  `TCC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (valid_q == '0) || rst_ni)

endmodule

// ===== design/tcc_div_step.sv =====
// One step of the restoring divider: settles a single quotient bit.
// Stand-alone; widths and bit position come from the parent.
module tcc_div_step #(
  parameter int PW    = 26,
  parameter int DW    = 13,
  parameter int QW    = 13,
  parameter int SHIFT = 0
) (
  input  logic [PW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW-1:0] q_i,
  output logic [PW-1:0] rem_o,
  output logic [QW-1:0] q_o
);

  logic [PW-1:0] trial;

  // Line the divisor up with this quotient bit
  assign trial = PW'(den_i) << SHIFT;

  // Subtract when it fits and set the bit
  always_comb begin
    rem_o = rem_i;
    q_o   = q_i;
    if (rem_i >= trial) begin
      rem_o        = rem_i - trial;
      q_o[SHIFT]   = 1'b1;
    end
  end

endmodule

// ===== tb/tcc_coord_checker.sv =====
// Result checker for the touch coordinate calibrator: tracks the calibration
// registers, predicts each item's coordinate and compares results in order.
// Depends on tcc_pkg, tcc_in_if and tcc_out_if.
`timescale 1ns / 1ps

module tcc_coord_checker import tcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [RAW_W-1:0] cfg_data_i,
  tcc_in_if                in_mon_i,
  tcc_out_if               out_mon_i,
  output int               fail_count_o,
  output int               backlog_o
);

  typedef struct packed {
    logic [RAW_W-1:0]   raw_reading;
    logic [COORD_W-1:0] screen_coord;
    logic               axis_done;
  } touch_result_t;

  // Coordinates owed by the block, oldest first
  touch_result_t coord_q[$];

  // Local copy of the calibration registers
  logic [RAW_W-1:0] h_min = RAW_MIN_RESET;
  logic [RAW_W-1:0] h_max = RAW_MAX_RESET;
  logic [RAW_W-1:0] v_min = RAW_MIN_RESET;
  logic [RAW_W-1:0] v_max = RAW_MAX_RESET;
  logic [OFS_W-1:0] h_ofs = OFS_RESET;
  logic [OFS_W-1:0] v_ofs = OFS_RESET;

  int errors = 0;

  assign fail_count_o = errors;

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // Join the bytes, clamp to the axis window, scale, mirror, shift, clamp
  function automatic touch_result_t predict_coord(logic axis, logic [BYTE_W-1:0] hi_b,
                                                  logic [BYTE_W-1:0] lo_b);
    touch_result_t res;
    int raw, win, lo, hi, span, scaled, c;
    logic [OFS_W-1:0] ofs;
    raw = int'({hi_b, lo_b}) >> 3;
    if (axis == AXIS_HORIZ) begin
      lo = int'(h_min); hi = int'(h_max); ofs = h_ofs; span = DEF_SCREEN_WIDTH;
    end else begin
      lo = int'(v_min); hi = int'(v_max); ofs = v_ofs; span = DEF_SCREEN_HEIGHT;
    end
    // empty window scales to zero rather than dividing
    if (hi <= lo) begin
      scaled = 0;
    end else begin
      win = raw;
      if (win < lo) win = lo;
      if (win > hi) win = hi;
      scaled = ((win - lo) * span) / (hi - lo);
    end
    c = span - scaled + int'($signed(ofs));
    if (c < 0) c = 0;
    if (c >= span) c = span - 1;
    res.raw_reading  = raw[RAW_W-1:0];
    res.screen_coord = c[COORD_W-1:0];
    res.axis_done    = axis;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    touch_result_t want;
    if (!rst_ni) begin
      h_min = RAW_MIN_RESET;
      h_max = RAW_MAX_RESET;
      v_min = RAW_MIN_RESET;
      v_max = RAW_MAX_RESET;
      h_ofs = OFS_RESET;
      v_ofs = OFS_RESET;
      coord_q.delete();
      backlog_o <= 0;
    end else begin
      // Check a delivered item against the oldest prediction
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (coord_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result raw=%0d coord=%0d axis=%0d",
                                    out_mon_i.raw_reading, out_mon_i.screen_coord,
                                    out_mon_i.axis_done));
        end else begin
          want = coord_q.pop_front();
          if (out_mon_i.raw_reading !== want.raw_reading)
            report_mismatch($sformatf("raw_reading got %0d want %0d",
                                      out_mon_i.raw_reading, want.raw_reading));
          if (out_mon_i.screen_coord !== want.screen_coord)
            report_mismatch($sformatf("screen_coord got %0d want %0d (raw %0d axis %0d)",
                                      out_mon_i.screen_coord, want.screen_coord,
                                      want.raw_reading, want.axis_done));
          if (out_mon_i.axis_done !== want.axis_done)
            report_mismatch($sformatf("axis_done got %0d want %0d",
                                      out_mon_i.axis_done, want.axis_done));
        end
      end
      // Track register writes; unknown indexes are dropped
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_HORIZ_MIN: h_min = cfg_data_i;
          REG_HORIZ_MAX: h_max = cfg_data_i;
          REG_VERT_MIN:  v_min = cfg_data_i;
          REG_VERT_MAX:  v_max = cfg_data_i;
          REG_HORIZ_OFS: h_ofs = cfg_data_i[OFS_W-1:0];
          REG_VERT_OFS:  v_ofs = cfg_data_i[OFS_W-1:0];
          default: ;
        endcase
      end
      // Queue the prediction for an accepted item
      if (in_mon_i.valid && in_mon_i.ready)
        coord_q.push_back(predict_coord(in_mon_i.command, in_mon_i.high_byte,
                                        in_mon_i.low_byte));
      backlog_o <= coord_q.size();
    end
  end

endmodule

// ===== tb/tb_touch_coordinate_calibrator.sv =====
// Testbench top for the touch coordinate calibrator: drives readings and
// calibration writes, stalls both channels at random and gives the verdict.
// Depends on tcc_pkg, tcc_in_if, tcc_out_if, the block and tcc_coord_checker.
`timescale 1ns / 1ps

module tb_touch_coordinate_calibrator;
  import tcc_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 3;
  localparam int MAX_IDLE        = 7;
  localparam int RAND_PHASES     = 12;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int HOLD_PHASE      = 3;
  localparam int BURST_PHASE     = 7;
  localparam int LONG_HOLD       = 200;
  localparam int DRAIN_CYCLES    = 24;
  localparam int LIMIT_CYCLES    = 200000;

  // Indexes past the last register; writes there must change nothing
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [RAW_W-1:0] cfg_data = '0;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit long_hold  = 1'b0;
  int fail_count;
  int backlog;
  int cycles = 0;

  tcc_in_if  in_ch ();
  tcc_out_if out_ch ();

  touch_coordinate_calibrator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  tcc_coord_checker checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_count_o (fail_count),
    .backlog_o    (backlog)
  );

  always #CLK_HALF clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [RAW_W-1:0] ofs_word(int pixels);
    return pixels[RAW_W-1:0];
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_reading(logic cmd, logic [BYTE_W-1:0] hi_b, logic [BYTE_W-1:0] lo_b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.high_byte <= hi_b;
    in_ch.low_byte  <= lo_b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted item has come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
  endtask

  // One write per cycle; the caller drops the enable after the last
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [RAW_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic program_cal(logic [RAW_W-1:0] hmin, logic [RAW_W-1:0] hmax,
                             logic [RAW_W-1:0] vmin, logic [RAW_W-1:0] vmax,
                             logic [RAW_W-1:0] hofs, logic [RAW_W-1:0] vofs);
    write_reg(REG_HORIZ_MIN, hmin);
    write_reg(REG_HORIZ_MAX, hmax);
    write_reg(REG_VERT_MIN, vmin);
    write_reg(REG_VERT_MAX, vmax);
    write_reg(REG_HORIZ_OFS, hofs);
    write_reg(REG_VERT_OFS, vofs);
  endtask

  // Mostly usable windows, with some empty, narrow and full-range ones
  task automatic rand_window(output logic [RAW_W-1:0] lo, output logic [RAW_W-1:0] hi);
    int mode, l;
    mode = $urandom_range(0, 9);
    case (mode)
      0: begin
        l  = $urandom_range(0, 8191);
        lo = RAW_W'(l);
        hi = RAW_W'($urandom_range(0, l));
      end
      1: begin
        lo = '0;
        hi = '1;
      end
      2: begin
        l  = $urandom_range(0, 8000);
        lo = RAW_W'(l);
        hi = RAW_W'(l + int'($urandom_range(1, 191)));
      end
      default: begin
        lo = RAW_W'($urandom_range(0, 2000));
        hi = RAW_W'($urandom_range(2500, 8191));
      end
    endcase
  endtask

  function automatic logic [RAW_W-1:0] rand_offset();
    if ($urandom_range(0, 1))
      return RAW_W'($urandom_range(0, 8191));
    return ofs_word(int'($urandom_range(0, 80)) - 40);
  endfunction

  task automatic random_cal();
    logic [RAW_W-1:0] hmin, hmax, vmin, vmax;
    rand_window(hmin, hmax);
    rand_window(vmin, vmax);
    program_cal(hmin, hmax, vmin, vmax, rand_offset(), rand_offset());
  endtask

  // Result side: random stalls per item, plus one long hold on request
  initial begin : drain
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
      end
      stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  initial begin : stimulus
    in_ch.valid     = 1'b0;
    in_ch.command   = AXIS_HORIZ;
    in_ch.high_byte = '0;
    in_ch.low_byte  = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Reset calibration: byte extremes, window edges and readings past the window
    send_reading(AXIS_HORIZ, 8'h00, 8'h00);
    send_reading(AXIS_VERT,  8'hFF, 8'hFF);
    send_reading(AXIS_HORIZ, 8'h7F, 8'hF8);
    send_reading(AXIS_VERT,  8'h80, 8'h07);
    send_reading(AXIS_HORIZ, 8'hAA, 8'h55);
    send_reading(AXIS_VERT,  8'h55, 8'hAA);
    settle();

    // Inner windows with offset extremes; spare indexes must be ignored
    program_cal(13'd200, 13'd3900, 13'd300, 13'd3800, ofs_word(255), ofs_word(-256));
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 13'h0AAA);
    cfg_we <= 1'b0;
    send_reading(AXIS_HORIZ, 8'h00, 8'h08);
    send_reading(AXIS_HORIZ, 8'hFF, 8'hFF);
    send_reading(AXIS_VERT,  8'h00, 8'h00);
    send_reading(AXIS_VERT,  8'hFF, 8'hFF);
    send_reading(AXIS_HORIZ, 8'h40, 8'h00);
    send_reading(AXIS_VERT,  8'h40, 8'h00);
    settle();

    // Empty windows: max equal to min and max below min; junk above offset bits
    program_cal(13'd5000, 13'd5000, 13'd8191, 13'd0, 13'h1FFF, ofs_word(-200));
    cfg_we <= 1'b0;
    send_reading(AXIS_HORIZ, 8'h12, 8'h34);
    send_reading(AXIS_VERT,  8'hFF, 8'hF8);
    settle();

    // Full-range windows
    program_cal(13'd0, 13'd8191, 13'd0, 13'd8191, ofs_word(0), ofs_word(-30));
    cfg_we <= 1'b0;
    send_reading(AXIS_HORIZ, 8'h00, 8'h00);
    send_reading(AXIS_HORIZ, 8'hFF, 8'hFF);
    send_reading(AXIS_VERT,  8'h00, 8'h00);
    send_reading(AXIS_VERT,  8'hFF, 8'hFF);
    send_reading(AXIS_VERT,  8'h80, 8'h00);
    settle();

    // Random phases, each under a fresh calibration
    for (int p = 0; p < RAND_PHASES; p++) begin
      random_cal();
      cfg_we <= 1'b0;
      tx_idle_on = (p != HOLD_PHASE) && (p != BURST_PHASE);
      rx_idle_on = (p != BURST_PHASE);
      if (p == HOLD_PHASE) long_hold = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        send_reading(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
                     BYTE_W'($urandom_range(0, 255)));
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && backlog == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
